@@ rtl/packed_field_unpacker_macros.svh @@
// assertion helpers for the field unpacker
`ifndef PACKED_FIELD_UNPACKER_MACROS_SVH
`define PACKED_FIELD_UNPACKER_MACROS_SVH

// implication or plain property, checked on every rising edge outside reset
`define PFU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition that must never be true outside reset
`define PFU_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/pfu_pkg.sv @@
package pfu_pkg;

	localparam int WordBits = 32;
	localparam int FieldMaxBits = 16;
	localparam int WidthBits = 5;
	localparam int CountBits = 6;
	localparam int QueueDepthDefault = 2;

	typedef struct packed {
		logic [WordBits-1:0] packed_word;
		logic                end_of_block;
	} in_item_t;

	typedef struct packed {
		logic [FieldMaxBits-1:0] field_value;
		logic                    last_of_word;
		logic                    end_of_block_out;
	} out_item_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [WordBits-1:0]  word;
		logic                 eob;
		logic [WidthBits-1:0] width;
		logic [CountBits-1:0] count;
	} work_t;

	// zero acts as one, anything above sixteen saturates
	function automatic logic [WidthBits-1:0] eff_width(input logic [WidthBits-1:0] w);
		logic [WidthBits-1:0] r;
		if (w == '0) begin
			r = WidthBits'(1);
		end else if (w > WidthBits'(FieldMaxBits)) begin
			r = WidthBits'(FieldMaxBits);
		end else begin
			r = w;
		end
		return r;
	endfunction

	// fields per word, floor(32 / w) for w in 1..16
	function automatic logic [CountBits-1:0] field_count(input logic [WidthBits-1:0] w);
		logic [CountBits-1:0] c;
		unique case (w) inside
			5'd1: c = 6'd32;
			5'd2: c = 6'd16;
			5'd3: c = 6'd10;
			5'd4: c = 6'd8;
			5'd5: c = 6'd6;
			5'd6: c = 6'd5;
			5'd7, 5'd8: c = 6'd4;
			5'd9, 5'd10: c = 6'd3;
			default: c = 6'd2;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/pfu_front.sv @@
module pfu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pfu_pkg::WidthBits-1:0] cfg_data,
	input  pfu_pkg::in_item_t            in_data,
	output pfu_pkg::work_t               work
);

	logic [pfu_pkg::WidthBits-1:0] width_q;
	logic [pfu_pkg::WidthBits-1:0] w_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= pfu_pkg::WidthBits'(1);
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_data;
		end
	end

	assign w_eff = pfu_pkg::eff_width(width_q);

	always_comb begin
		work.word  = in_data.packed_word;
		work.eob   = in_data.end_of_block;
		work.width = w_eff;
		work.count = pfu_pkg::field_count(w_eff);
	end

endmodule

@@ rtl/pfu_queue.sv @@
module pfu_queue #(
	parameter int Depth = pfu_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfu_pkg::work_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output pfu_pkg::work_t pop_data
);

	localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntBits = $clog2(Depth + 1);

	pfu_pkg::work_t     mem_q [Depth];
	logic [PtrBits-1:0] wr_ptr_q;
	logic [PtrBits-1:0] rd_ptr_q;
	logic [CntBits-1:0] cnt_q;

	assign full      = (cnt_q == CntBits'(Depth));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/pfu_back.sv @@
module pfu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  pfu_pkg::work_t     q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output pfu_pkg::out_item_t out_data
);

	logic                                busy_q;
	logic [pfu_pkg::WordBits-1:0]        word_q;
	logic                                eob_q;
	logic [pfu_pkg::WidthBits-1:0]       width_q;
	logic [pfu_pkg::CountBits-1:0]       remain_q;
	logic                                out_valid_q;
	pfu_pkg::out_item_t                  out_data_q;

	logic                                adv;
	logic                                last;
	logic [pfu_pkg::WidthBits-1:0]       shamt;
	logic [pfu_pkg::FieldMaxBits-1:0]    field;

	// output register frees up when empty or when its item is taken
	assign adv   = !out_valid_q || !out_stall;
	assign last  = (remain_q == pfu_pkg::CountBits'(1));
	assign q_pop = q_not_empty && (!busy_q || (adv && last));

	// top w bits of the word, right aligned
	assign shamt = pfu_pkg::WidthBits'(pfu_pkg::FieldMaxBits) - width_q;
	assign field = word_q[pfu_pkg::WordBits-1 -: pfu_pkg::FieldMaxBits] >> shamt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q   <= 1'b1;
				remain_q <= q_data.count;
			end else if (adv && busy_q) begin
				busy_q   <= !last;
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			out_data_q.field_value      <= field;
			out_data_q.last_of_word     <= last;
			out_data_q.end_of_block_out <= last && eob_q;
		end
		if (q_pop) begin
			word_q  <= q_data.word;
			eob_q   <= q_data.eob;
			width_q <= q_data.width;
		end else if (adv && busy_q) begin
			word_q <= word_q << width_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/packed_field_unpacker.sv @@
// Packed field unpacker. Each input item is a 32-bit word (first byte in bits
// 31 to 24) plus an end-of-block flag; it is cut into floor(32/w) fields of
// the configured width w (1 to 16, 0 acts as 1, above 16 as 16), sent most
// significant first, with leftover low bits dropped. The last field of a word
// carries last_of_word and the word's end-of-block flag. The width is taken
// through the cfg channel (always ready) and is latched per word on input.
// Rate: the output emitter produces one field per cycle while out_stall is
// low, so a word yields floor(32/w) fields: 32 at width 1 down to 2 at widths
// 11 to 16, with consecutive words following without a gap. Input words are
// taken every cycle while the QueueDepth-entry queue between the input side
// and the emitter has room, then pass the queue, word and output registers.
module packed_field_unpacker #(
	parameter int QueueDepth = pfu_pkg::QueueDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfu_pkg::WidthBits-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pfu_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pfu_pkg::out_item_t            out_data
);

	pfu_pkg::work_t work;
	pfu_pkg::work_t q_data;
	logic           q_full;
	logic           q_not_empty;
	logic           q_pop;

	assign in_stall = q_full;

	pfu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.work      (work)
	);

	pfu_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (work),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	pfu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

@@ rtl/pfu_checker.sv @@
`include "packed_field_unpacker_macros.svh"

module pfu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_ready,
	input logic               out_valid,
	input logic               out_stall,
	input pfu_pkg::out_item_t out_data
);

	// a stalled output item stays put
	`PFU_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output item changed")

	// end of block only ever rides on the last field of a word
	`PFU_NEVER(a_eob_on_last, clk, arst_n, out_valid && out_data.end_of_block_out && !out_data.last_of_word, "end of block on a field that is not last of word")

	// the width register is always writable
	`PFU_NEVER(a_cfg_ready, clk, arst_n, !cfg_ready, "cfg channel not ready")

endmodule

bind packed_field_unpacker pfu_checker u_pfu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

@@ bench/packed_field_unpacker_test.sv @@
module packed_field_unpacker_test;

	logic clk;
	logic arst_n = 1'b0;

	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [pfu_pkg::WidthBits-1:0] cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	pfu_pkg::in_item_t             in_data = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	pfu_pkg::out_item_t            out_data;

	packed_field_unpacker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	pfu_pkg::in_item_t             word_q[$];
	pfu_pkg::out_item_t            pending_fields[$];
	pfu_pkg::out_item_t            want;
	logic [pfu_pkg::WidthBits-1:0] width_reg = 5'd1;
	int                            errors = 0;
	int                            src_gap = 0;
	int                            sink_gap = 0;
	int                            src_pct = 0;
	int                            sink_pct = 0;
	bit                            quiet = 1'b0;
	bit                            start_hold = 1'b0;
	logic                          long_hold = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// cut one word into its fields at the current width, msb first
	function automatic void expand_word(input pfu_pkg::in_item_t item);
		int w;
		int count;
		int k;
		pfu_pkg::out_item_t f;
		w = (width_reg == '0) ? 1 :
			(width_reg > pfu_pkg::FieldMaxBits) ? pfu_pkg::FieldMaxBits : int'(width_reg);
		count = pfu_pkg::WordBits / w;
		for (k = 0; k < count; k++) begin
			f.field_value = 16'((item.packed_word >> (pfu_pkg::WordBits - (k + 1) * w)) &
				((32'd1 << w) - 32'd1));
			f.last_of_word = (k == count - 1);
			f.end_of_block_out = (k == count - 1) && item.end_of_block;
			pending_fields = {pending_fields, f};
		end
	endfunction

	function automatic void push_word(input logic [pfu_pkg::WordBits-1:0] w, input logic eob);
		pfu_pkg::in_item_t item;
		item.packed_word = w;
		item.end_of_block = eob;
		word_q = {word_q, item};
	endfunction

	function automatic void random_words(input int n);
		int i;
		int r;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				push_word('1, $urandom_range(0, 3) == 0);
			end else if (r == 1) begin
				push_word('0, $urandom_range(0, 3) == 0);
			end else begin
				push_word($urandom, $urandom_range(0, 3) == 0);
			end
		end
	endfunction

	task automatic write_width(input logic [pfu_pkg::WidthBits-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		width_reg = value;
	endtask

	// wait until every queued item is taken and every field has come out
	task automatic settle;
		while (word_q.size() != 0 || in_valid || pending_fields.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			src_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				expand_word(in_data);
			if (in_valid && in_stall) begin
				// item held until taken
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (word_q.size() != 0 && !quiet && $urandom_range(1, 100) <= src_pct) begin
				src_gap <= $urandom_range(0, 2);
				in_valid <= 1'b0;
			end else if (word_q.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= word_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver and field check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_fields.size() == 0) begin
					$display("%0t: unexpected field, expected none, got %h", $time, out_data);
					errors++;
				end else begin
					want = pending_fields.pop_front();
					if (out_data.field_value !== want.field_value) begin
						$display("%0t: field_value expected %h got %h", $time,
							want.field_value, out_data.field_value);
						errors++;
					end
					if (out_data.last_of_word !== want.last_of_word) begin
						$display("%0t: last_of_word expected %b got %b", $time,
							want.last_of_word, out_data.last_of_word);
						errors++;
					end
					if (out_data.end_of_block_out !== want.end_of_block_out) begin
						$display("%0t: end_of_block_out expected %b got %b", $time,
							want.end_of_block_out, out_data.end_of_block_out);
						errors++;
					end
				end
			end
			if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(1, 100) <= sink_pct) begin
				sink_gap <= $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= long_hold;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (start_hold);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (150) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		logic [pfu_pkg::WidthBits-1:0] widths[9];
		int p;
		widths = '{5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd10, 5'd13, 5'd15, 5'd0};
		widths[8] = 5'($urandom_range(0, 31));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width 1 out of reset
		push_word(32'h0000_0000, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b1);
		push_word(32'h8000_0001, 1'b0);
		push_word(32'h5A5A_5A5A, 1'b1);
		settle;

		// zero behaves as width 1
		write_width(5'd0);
		push_word(32'hC3C3_0F0F, 1'b1);
		push_word(32'h0000_0001, 1'b0);
		settle;

		src_pct = 20;
		sink_pct = 20;
		write_width(5'd16);
		push_word(32'hFFFF_0000, 1'b0);
		push_word(32'h0000_FFFF, 1'b1);
		push_word(32'h1234_5678, 1'b0);
		settle;

		// widths above sixteen saturate
		write_width(5'd17);
		push_word(32'hABCD_EF01, 1'b1);
		push_word(32'hFFFF_FFFF, 1'b0);
		settle;
		write_width(5'd31);
		push_word(32'h8001_8001, 1'b1);
		push_word(32'h7FFE_7FFE, 1'b0);
		settle;

		// leftover low bits dropped
		write_width(5'd3);
		push_word(32'hFFFF_FFFF, 1'b1);
		push_word(32'h0000_0003, 1'b0);
		settle;
		write_width(5'd11);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h0000_03FF, 1'b1);
		settle;

		write_width(5'd8);
		push_word(32'h0102_0304, 1'b0);
		push_word(32'hFF00_80FF, 1'b1);
		settle;

		for (p = 0; p < 9; p++) begin
			src_pct = 15 * $urandom_range(0, 2);
			sink_pct = 15 * $urandom_range(0, 2);
			write_width(widths[p]);
			random_words(14);
			settle;
		end

		// receiver holds off while the sender keeps offering
		src_pct = 0;
		sink_pct = 10;
		write_width(5'd2);
		start_hold = 1'b1;
		random_words(12);
		settle;

		quiet = 1'b1;
		write_width(5'd6);
		random_words(14);
		settle;

		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pfu_pkg.sv
rtl/pfu_front.sv
rtl/pfu_queue.sv
rtl/pfu_back.sv
rtl/packed_field_unpacker.sv
rtl/pfu_checker.sv
bench/packed_field_unpacker_test.sv
